// ===== sv/mtwb_pkg.sv =====
// Shared constants and types for the mutex table with wait bitmaps.
`default_nettype none

package mtwb_pkg;

   // Default sizes
   localparam int DEF_MUTEX_COUNT  = 8;
   localparam int DEF_THREAD_COUNT = 32;

   // Stream widths
   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 48;
   localparam int RSP_TUSER_W = 4;

   // Request modes
   localparam logic [2:0] MODE_ALLOC  = 3'd0;
   localparam logic [2:0] MODE_FREE   = 3'd1;
   localparam logic [2:0] MODE_LOCK   = 3'd2;
   localparam logic [2:0] MODE_TLOCK  = 3'd3;
   localparam logic [2:0] MODE_UNLOCK = 3'd4;

   // Response status codes
   localparam logic [3:0] ST_RELEASED  = 4'd0;
   localparam logic [3:0] ST_HANDOFF   = 4'd1;
   localparam logic [3:0] ST_ACQUIRED  = 4'd2;
   localparam logic [3:0] ST_QUEUED    = 4'd3;
   localparam logic [3:0] ST_NOT_ALLOC = 4'd4;
   localparam logic [3:0] ST_NOT_OWNER = 4'd5;
   localparam logic [3:0] ST_ALLOCATED = 4'd6;
   localparam logic [3:0] ST_NONE_FREE = 4'd7;
   localparam logic [3:0] ST_FREED     = 4'd8;

   // Control sequencer states
   typedef enum logic [1:0] {
      FSM_IDLE = 2'b01,
      FSM_EXEC = 2'b10
   } fsm_type;

endpackage

`default_nettype wire

// ===== sv/mutex_table_with_wait_bitmaps_core.sv =====
// Mutex table with per-mutex wait bitmaps: top level.
// A request and its mutex entry are registered on acceptance; the read-modify-write of the entry
// then completes once the output register is free, and no new request is taken until it has.
// A request is taken while the previous response still waits in the output register.
// Reset (synchronous): allocation map, clock-wait map and entry valid bits clear, check enabled.
// Entries never written since reset read as free with no waiters; no clearing pass.
`default_nettype none

module mutex_table_with_wait_bitmaps_core
   import mtwb_pkg::*;
#(
   parameter int MUTEX_COUNT  = DEF_MUTEX_COUNT,
   parameter int THREAD_COUNT = DEF_THREAD_COUNT
) (
   input  wire                    clock,
   input  wire                    reset,
   // request stream
   input  wire                    req_tvalid,
   output logic                   req_tready,
   // [2:0] mutex_id, [7:3] thread_id, [39:8] timeout_ms, [71:40] now_tick
   input  wire [REQ_TDATA_W-1:0]  req_tdata,
   // [2:0] mode
   input  wire [REQ_TUSER_W-1:0]  req_tuser,
   // response stream
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   // [2:0] mutex_out, [3] caller_waits, [4] caller_preset_timeout,
   // [36:5] deadline, [37] wake_valid, [42:38] wake_thread, [47:43] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   // [3:0] status
   output logic [RSP_TUSER_W-1:0] rsp_tuser,
   // configuration write
   input  wire                    csr_valid,
   output logic                   csr_ready,
   input  wire                    csr_wdata
);

   localparam int MIDX_W = (MUTEX_COUNT > 1) ? $clog2(MUTEX_COUNT) : 1;
   localparam int TIDX_W = $clog2(THREAD_COUNT);

   typedef struct packed {
      logic                    held;
      logic [TIDX_W-1:0]       owner;
      logic [THREAD_COUNT-1:0] waiters;
   } entry_type;

   // Control and configuration state
   fsm_type                 state_ff, state_in;
   logic                    chk_en_ff;
   logic [MUTEX_COUNT-1:0]  alloc_ff, alloc_in;
   logic [THREAD_COUNT-1:0] cwait_ff, cwait_in;
   logic [MUTEX_COUNT-1:0]  ent_vld_ff;

   // Captured request
   logic [2:0]  mode_ff;
   logic [2:0]  mid_ff;
   logic [4:0]  tid_ff;
   logic [31:0] tmo_ff;
   logic [31:0] now_ff;

   // Memories
   entry_type   ent_mem [MUTEX_COUNT];
   logic [31:0] dl_mem  [THREAD_COUNT];
   entry_type   rd_data_ff;
   logic        rd_vld_ff;

   // Response register
   logic                   rsp_vld_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_TUSER_W-1:0] rsp_user_ff, rsp_user_in;

   // Request unpacking
   logic [2:0]  req_mode;
   logic [2:0]  req_mid;
   logic [MIDX_W-1:0] req_addr;

   // Update path
   logic              accept;
   logic              fire;
   logic [MIDX_W-1:0] maddr;
   logic [TIDX_W-1:0] taddr;
   logic              m_ok;
   logic              t_ok;
   logic              m_alloc;
   entry_type         ent, ent_new;
   logic              ent_wr;
   logic              dl_wr;
   logic              free_found;
   logic [MIDX_W-1:0] free_idx;
   logic              wait_found;
   logic [TIDX_W-1:0] wait_idx;
   logic [3:0]        status;
   logic [2:0]        mout;
   logic              waits;
   logic              preset;
   logic [31:0]       dl;
   logic              wv;
   logic [4:0]        wt;

   assign req_mode = req_tuser[2:0];
   assign req_mid  = req_tdata[2:0];
   assign req_addr = MIDX_W'(req_mid);

   assign req_tready = (state_ff == FSM_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign fire       = (state_ff == FSM_EXEC) && (!rsp_vld_ff || rsp_tready);
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (accept) state_in = FSM_EXEC;
         end
         FSM_EXEC: begin
            if (fire) state_in = FSM_IDLE;
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FSM_IDLE;
         chk_en_ff  <= 1'b1;
         alloc_ff   <= '0;
         cwait_ff   <= '0;
         ent_vld_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) chk_en_ff <= csr_wdata;
         if (fire) begin
            alloc_ff <= alloc_in;
            cwait_ff <= cwait_in;
            if (ent_wr) ent_vld_ff[maddr] <= 1'b1;
         end
         if (fire) rsp_vld_ff <= 1'b1;
         else if (rsp_tready) rsp_vld_ff <= 1'b0;
      end
   end

   // Request capture and entry read
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_mode;
         mid_ff     <= req_mid;
         tid_ff     <= req_tdata[7:3];
         tmo_ff     <= req_tdata[39:8];
         now_ff     <= req_tdata[71:40];
         rd_data_ff <= ent_mem[req_addr];
         rd_vld_ff  <= ent_vld_ff[req_addr];
      end
   end

   // Entry and deadline write-back
   always_ff @(posedge clock) begin
      if (fire && ent_wr) ent_mem[maddr] <= ent_new;
      if (fire && dl_wr) dl_mem[taddr] <= dl;
   end

   // Response register
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= rsp_user_in;
      end
   end

   // Range checks and entry view
   assign maddr   = MIDX_W'(mid_ff);
   assign taddr   = TIDX_W'(tid_ff);
   assign m_ok    = {3'b000, mid_ff} < 6'(MUTEX_COUNT);
   assign t_ok    = {1'b0, tid_ff} < 6'(THREAD_COUNT);
   assign m_alloc = m_ok && alloc_ff[maddr];
   assign ent     = rd_vld_ff ? rd_data_ff : '0;

   // Lowest unallocated mutex
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MUTEX_COUNT - 1; i >= 0; i--) begin
         if (!alloc_ff[i]) begin
            free_found = 1'b1;
            free_idx   = MIDX_W'(i);
         end
      end
   end

   // Lowest waiting thread
   always_comb begin
      wait_found = 1'b0;
      wait_idx   = '0;
      for (int i = THREAD_COUNT - 1; i >= 0; i--) begin
         if (ent.waiters[i]) begin
            wait_found = 1'b1;
            wait_idx   = TIDX_W'(i);
         end
      end
   end

   // Request execution
   always_comb begin
      status   = ST_NOT_ALLOC;
      mout     = 3'd0;
      waits    = 1'b0;
      preset   = 1'b0;
      dl       = 32'd0;
      wv       = 1'b0;
      wt       = 5'd0;
      alloc_in = alloc_ff;
      cwait_in = cwait_ff;
      ent_new  = ent;
      ent_wr   = 1'b0;
      dl_wr    = 1'b0;
      case (mode_ff)
         MODE_ALLOC: begin
            status = ST_NONE_FREE;
            if (free_found) begin
               alloc_in[free_idx] = 1'b1;
               status = ST_ALLOCATED;
               mout   = 3'(free_idx);
            end
         end
         MODE_FREE: begin
            if (m_alloc) begin
               alloc_in[maddr] = 1'b0;
               status = ST_FREED;
            end
         end
         MODE_LOCK, MODE_TLOCK, MODE_UNLOCK: begin
            if (!m_ok || (chk_en_ff && !m_alloc)) begin
               status = ST_NOT_ALLOC;
            end else if (!t_ok) begin
               status = ST_NOT_OWNER;
            end else if (mode_ff == MODE_UNLOCK) begin
               if (!ent.held || ent.owner != taddr) begin
                  status = ST_NOT_OWNER;
               end else if (!wait_found) begin
                  // no waiter: release
                  ent_new.held  = 1'b0;
                  ent_new.owner = '0;
                  ent_wr = 1'b1;
                  status = ST_RELEASED;
               end else begin
                  // hand off to lowest waiter
                  ent_new.owner = wait_idx;
                  ent_new.waiters[wait_idx] = 1'b0;
                  cwait_in[wait_idx] = 1'b0;
                  ent_wr = 1'b1;
                  status = ST_HANDOFF;
                  mout   = mid_ff;
                  wv     = 1'b1;
                  wt     = 5'(wait_idx);
               end
            end else if (!ent.held) begin
               ent_new.held  = 1'b1;
               ent_new.owner = taddr;
               ent_wr = 1'b1;
               status = ST_ACQUIRED;
               mout   = mid_ff;
            end else begin
               // held: queue caller
               ent_new.waiters[taddr] = 1'b1;
               ent_wr = 1'b1;
               status = ST_QUEUED;
               waits  = 1'b1;
               if (mode_ff == MODE_TLOCK) begin
                  dl     = now_ff + tmo_ff;
                  dl_wr  = 1'b1;
                  cwait_in[taddr] = 1'b1;
                  preset = 1'b1;
               end
            end
         end
         default: begin
            status = ST_NOT_ALLOC;
         end
      endcase
   end

   // Response packing
   assign rsp_data_in = {5'd0, wt, wv, dl, preset, waits, mout};
   assign rsp_user_in = status;

endmodule

`default_nettype wire
